@@ design/pdp_pkg.sv @@
// Shared types for the projectile detonation point pipeline.
`default_nettype none

package pdp_pkg;

  typedef enum logic [1:0] {
    FUNC_POS  = 2'd0,
    FUNC_TIME = 2'd1,
    FUNC_LAND = 2'd2,
    FUNC_DET  = 2'd3
  } func_e;

  // Item fields that ride along the root and divide pipelines
  typedef struct packed {
    func_e              func;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] gz;
    logic signed [23:0] tv;
    logic signed [32:0] dz;
    logic               lin_ok;
    logic               disc_neg;
    logic               reach;
  } side_t;

  // Input of the motion pipeline
  typedef struct packed {
    side_t       side;
    logic [48:0] ts;
    logic        land;
    logic [22:0] gtime;
  } mot_t;

  // One result item
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [22:0]        gtime;
    logic               reach;
    logic               burst;
  } res_t;

endpackage

`default_nettype wire

@@ design/projectile_detonation_point.sv @@
// Top level of the projectile detonation point pipeline.
`default_nettype none

// Ballistic query engine. Each input transfer carries a throw (origin,
// velocity, ground plane Z, time or fuse, mode in tuser); each one yields
// exactly one output transfer with the point, the ground time and two flags.
// Fully pipelined: one transfer accepted per clock while s_axis_tready is
// high. A result passes 89 register stages (2 front, 32 square-root, 1 setup,
// 49 divider stages for the ground time, 1 select, 3 motion and the output
// register). Latency is set by the bit-serial root and quotient chains. A
// two-entry output buffer lets the input keep streaming while a result
// waits; s_axis_tready drops only when both entries are full. Gravity
// (Q16.8, resets to 980.0) is written through the cfg channel, which is
// always ready; write it only while no transfer is in flight.
module projectile_detonation_point (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [23:0]  cfg_data_i,    // gravity
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // origin_x, origin_y, origin_z, velocity_x, velocity_y, velocity_z,
  // ground_height, time_value
  input  wire logic [247:0] s_axis_tdata,
  input  wire logic [1:0]   s_axis_tuser,  // func
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // point_x, point_y, point_z, ground_time, one pad bit
  output logic [119:0]      m_axis_tdata,
  output logic [1:0]        m_axis_tuser   // reaches_ground, burst_on_ground
);
  import pdp_pkg::*;

  localparam logic signed [23:0] GravReset = 24'sd250880;
  localparam logic [22:0]        GtimeMax  = 23'h7F_FFFF;

  // gravity register
  logic signed [23:0] gravity_q;
  logic               g_pos;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= GravReset;
    end else if (cfg_valid_i) begin
      gravity_q <= cfg_data_i;
    end
  end

  assign g_pos = !gravity_q[23] && (gravity_q != '0);

  // whole pipeline moves unless the output buffer is full
  logic adv;
  logic skid_valid_q;
  assign adv           = !skid_valid_q;
  assign s_axis_tready = adv;

  // stage A: dz, Vz*Vz, g*dz
  logic               a_valid_q;
  side_t              a_side_d, a_side_q;
  logic signed [63:0] a_vzsq_d, a_vzsq_q;
  logic signed [56:0] a_gdz_d, a_gdz_q;

  always_comb begin
    a_side_d.func     = func_e'(s_axis_tuser);
    a_side_d.ox       = s_axis_tdata[31:0];
    a_side_d.oy       = s_axis_tdata[63:32];
    a_side_d.oz       = s_axis_tdata[95:64];
    a_side_d.vx       = s_axis_tdata[127:96];
    a_side_d.vy       = s_axis_tdata[159:128];
    a_side_d.vz       = s_axis_tdata[191:160];
    a_side_d.gz       = s_axis_tdata[223:192];
    a_side_d.tv       = s_axis_tdata[247:224];
    a_side_d.dz       = {a_side_d.oz[31], a_side_d.oz} - {a_side_d.gz[31], a_side_d.gz};
    a_side_d.lin_ok   = a_side_d.vz[31] && !a_side_d.dz[32];
    a_side_d.disc_neg = 1'b0;
    a_side_d.reach    = 1'b0;
    a_vzsq_d          = a_side_d.vz * a_side_d.vz;
    a_gdz_d           = gravity_q * a_side_d.dz;
  end

  // stage B: discriminant
  logic               b_valid_q;
  side_t              b_side_d, b_side_q;
  logic [63:0]        b_rad_d, b_rad_q;
  logic signed [64:0] disc;

  always_comb begin
    disc              = {a_vzsq_q[63], a_vzsq_q} + {{7{a_gdz_q[56]}}, a_gdz_q, 1'b0};
    b_side_d          = a_side_q;
    b_side_d.disc_neg = disc[64];
    b_rad_d           = disc[64] ? '0 : disc[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= s_axis_tvalid;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_side_q <= a_side_d;
      a_vzsq_q <= a_vzsq_d;
      a_gdz_q  <= a_gdz_d;
      b_side_q <= b_side_d;
      b_rad_q  <= b_rad_d;
    end
  end

  // square root
  logic        sq_valid;
  side_t       sq_side;
  logic [31:0] sq_root;

  pdp_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (b_valid_q),
    .side_i  (b_side_q),
    .rad_i   (b_rad_q),
    .valid_o (sq_valid),
    .side_o  (sq_side),
    .root_o  (sq_root)
  );

  // stage C: later root numerator, or the straight-line drop
  logic               c_valid_q;
  side_t              c_side_d, c_side_q;
  logic [48:0]        c_dvd_d, c_dvd_q;
  logic [31:0]        c_dvs_d, c_dvs_q;
  logic signed [33:0] num;
  logic [32:0]        vz_neg;

  always_comb begin
    num      = {{2{sq_side.vz[31]}}, sq_side.vz} + {2'b0, sq_root};
    vz_neg   = -{sq_side.vz[31], sq_side.vz};
    c_side_d = sq_side;
    if (g_pos) begin
      c_side_d.reach = !sq_side.disc_neg && !num[33];
      c_dvd_d        = {num[32:0], 16'h0};
      c_dvs_d        = {8'h0, gravity_q};
    end else begin
      c_side_d.reach = sq_side.lin_ok;
      c_dvd_d        = {sq_side.dz[32:0], 16'h0};
      c_dvs_d        = vz_neg[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (adv) begin
      c_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_side_q <= c_side_d;
      c_dvd_q  <= c_dvd_d;
      c_dvs_q  <= c_dvs_d;
    end
  end

  // ground time divide
  logic        dv_valid;
  side_t       dv_side;
  logic [48:0] dv_quot;

  pdp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (c_valid_q),
    .side_i     (c_side_q),
    .dividend_i (c_dvd_q),
    .divisor_i  (c_dvs_q),
    .valid_o    (dv_valid),
    .side_o     (dv_side),
    .quot_o     (dv_quot)
  );

  // stage D: landing decision and the evaluation time
  logic        d_valid_q;
  mot_t        d_mot_d, d_mot_q;
  logic [48:0] t_in;

  always_comb begin
    t_in         = dv_side.tv[23] ? '0 : {26'b0, dv_side.tv[22:0]};
    d_mot_d.side = dv_side;
    d_mot_d.land = dv_side.reach &&
                   ((dv_side.func == FUNC_LAND) ||
                    ((dv_side.func == FUNC_DET) && (dv_quot <= t_in)));
    if (d_mot_d.land) begin
      d_mot_d.ts = dv_quot;
    end else if (dv_side.func == FUNC_LAND) begin
      d_mot_d.ts = '0;   // plane never reached: origin
    end else begin
      d_mot_d.ts = t_in;
    end
    if (!dv_side.reach) begin
      d_mot_d.gtime = '0;
    end else if (dv_quot[48:23] != '0) begin
      d_mot_d.gtime = GtimeMax;
    end else begin
      d_mot_d.gtime = dv_quot[22:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (adv) begin
      d_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_mot_q <= d_mot_d;
    end
  end

  // position terms
  logic mo_valid;
  res_t mo_res;

  pdp_motion u_motion (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (d_valid_q),
    .mot_i     (d_mot_q),
    .gravity_i (gravity_q),
    .valid_o   (mo_valid),
    .res_o     (mo_res)
  );

  // output register plus skid entry
  logic out_valid_q;
  res_t out_q, skid_q;
  logic take;

  assign take = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (mo_valid) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (mo_valid) begin
      if (!out_valid_q || take) begin
        out_q <= mo_res;
      end else begin
        skid_q <= mo_res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.gtime, out_q.pz, out_q.py, out_q.px};
  assign m_axis_tuser  = {out_q.burst, out_q.reach};

endmodule

`default_nettype wire

@@ design/pdp_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module pdp_isqrt (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire logic           valid_i,
  input  wire pdp_pkg::side_t side_i,
  input  wire logic [63:0]    rad_i,
  output logic                valid_o,
  output pdp_pkg::side_t      side_o,
  output logic [31:0]         root_o
);
  import pdp_pkg::*;

  localparam int Steps = 32;

  logic [63:0] n_q     [Steps];
  logic [63:0] r_q     [Steps];
  side_t       side_q  [Steps];
  logic        valid_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] n_in, r_in, n_d, r_d;
    logic [64:0] trial;
    side_t       s_in;
    logic        v_in;

    if (k == 0) begin : g_first
      assign n_in = rad_i;
      assign r_in = '0;
      assign s_in = side_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
      assign s_in = side_q[k-1];
      assign v_in = valid_q[k-1];
    end

    always_comb begin
      trial = {1'b0, r_in} + {1'b0, Bit};
      if ({1'b0, n_in} >= trial) begin
        n_d = n_in - trial[63:0];
        r_d = (r_in >> 1) + Bit;
      end else begin
        n_d = n_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (adv_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        n_q[k]    <= n_d;
        r_q[k]    <= r_d;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign side_o  = side_q[Steps-1];
  assign root_o  = r_q[Steps-1][31:0];

endmodule

`default_nettype wire

@@ design/pdp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module pdp_div (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire logic           valid_i,
  input  wire pdp_pkg::side_t side_i,
  input  wire logic [48:0]    dividend_i,
  input  wire logic [31:0]    divisor_i,
  output logic                valid_o,
  output pdp_pkg::side_t      side_o,
  output logic [48:0]         quot_o
);
  import pdp_pkg::*;

  localparam int Steps = 49;

  logic [31:0] rem_q   [Steps];
  logic [48:0] dq_q    [Steps];
  logic [31:0] dvs_q   [Steps];
  side_t       side_q  [Steps];
  logic        valid_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [31:0] rem_in, dvs_in, rem_d;
    logic [48:0] dq_in, dq_d;
    logic [32:0] sh, diff;
    logic        ge;
    side_t       s_in;
    logic        v_in;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dividend_i;
      assign dvs_in = divisor_i;
      assign s_in   = side_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dq_in  = dq_q[k-1];
      assign dvs_in = dvs_q[k-1];
      assign s_in   = side_q[k-1];
      assign v_in   = valid_q[k-1];
    end

    always_comb begin
      sh    = {rem_in, dq_in[48]};
      diff  = sh - {1'b0, dvs_in};
      ge    = (sh >= {1'b0, dvs_in});
      rem_d = ge ? diff[31:0] : sh[31:0];
      dq_d  = {dq_in[47:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (adv_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k]  <= rem_d;
        dq_q[k]   <= dq_d;
        dvs_q[k]  <= dvs_in;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign side_o  = side_q[Steps-1];
  assign quot_o  = dq_q[Steps-1];

endmodule

`default_nettype wire

@@ design/pdp_motion.sv @@
// Position terms v*t and g*t*t/2, summed and saturated; three register stages.
`default_nettype none

module pdp_motion (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic               valid_i,
  input  wire pdp_pkg::mot_t      mot_i,
  input  wire logic signed [23:0] gravity_i,
  output logic                    valid_o,
  output pdp_pkg::res_t           res_o
);
  import pdp_pkg::*;

  localparam logic [40:0] TermLimit = 41'h100_0000_0000;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [32:0] n;
    n = -{v[31], v};
    return v[31] ? n[31:0] : v[31:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [43:0] v);
    if (v > 44'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -44'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // stage 1: magnitudes, clamped time, t*t
  logic        m1_valid_q;
  mot_t        m1_mot_q;
  logic [31:0] mag_d [3];
  logic [31:0] mag_q [3];
  logic        neg_d [3];
  logic        neg_q [3];
  logic [32:0] hi_d, hi_q;
  logic [15:0] lo_q;
  logic [45:0] tt_d, tt_q;
  logic [23:0] gmag_d, gmag_q;
  logic        gneg_q;

  always_comb begin
    logic [24:0] gn;
    mag_d[0] = mag32(mot_i.side.vx);
    mag_d[1] = mag32(mot_i.side.vy);
    mag_d[2] = mag32(mot_i.side.vz);
    neg_d[0] = mot_i.side.vx[31];
    neg_d[1] = mot_i.side.vy[31];
    neg_d[2] = mot_i.side.vz[31];
    hi_d     = mot_i.ts[48] ? 33'h1_0000_0000 : mot_i.ts[48:16];
    tt_d     = {23'b0, mot_i.ts[22:0]} * {23'b0, mot_i.ts[22:0]};
    gn       = -{gravity_i[23], gravity_i};
    gmag_d   = gravity_i[23] ? gn[23:0] : gravity_i[23:0];
  end

  // stage 2: partial products
  logic        m2_valid_q;
  mot_t        m2_mot_q;
  logic [64:0] ph_d [3];
  logic [64:0] ph_q [3];
  logic [47:0] pl_d [3];
  logic [47:0] pl_q [3];
  logic        neg2_q [3];
  logic [46:0] ga_d, ga_q, gb_d, gb_q;
  logic        gneg2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ph_d[i] = {33'b0, mag_q[i]} * {32'b0, hi_q};
      pl_d[i] = {16'b0, mag_q[i]} * {32'b0, lo_q};
    end
    ga_d = {23'b0, gmag_q} * {24'b0, tt_q[45:23]};
    gb_d = {23'b0, gmag_q} * {24'b0, tt_q[22:0]};
  end

  // stage 3: terms toward zero, velocity term clamped
  logic               m3_valid_q;
  mot_t               m3_mot_q;
  logic signed [41:0] term_d [3];
  logic signed [41:0] term_q [3];
  logic signed [38:0] gterm_d, gterm_q;

  always_comb begin
    logic [65:0] p;
    logic [40:0] pc;
    logic [47:0] gs;
    for (int i = 0; i < 3; i++) begin
      p         = {1'b0, ph_q[i]} + {34'b0, pl_q[i][47:16]};
      pc        = (p > {25'b0, TermLimit}) ? TermLimit : p[40:0];
      term_d[i] = neg2_q[i] ? -{1'b0, pc} : {1'b0, pc};
    end
    gs      = {1'b0, ga_q} + {24'b0, gb_q[46:23]};
    gterm_d = gneg2_q ? -{1'b0, gs[47:10]} : {1'b0, gs[47:10]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
      m2_valid_q <= 1'b0;
      m3_valid_q <= 1'b0;
    end else if (adv_i) begin
      m1_valid_q <= valid_i;
      m2_valid_q <= m1_valid_q;
      m3_valid_q <= m2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      m1_mot_q <= mot_i;
      mag_q    <= mag_d;
      neg_q    <= neg_d;
      hi_q     <= hi_d;
      lo_q     <= mot_i.ts[15:0];
      tt_q     <= tt_d;
      gmag_q   <= gmag_d;
      gneg_q   <= gravity_i[23];

      m2_mot_q <= m1_mot_q;
      ph_q     <= ph_d;
      pl_q     <= pl_d;
      neg2_q   <= neg_q;
      ga_q     <= ga_d;
      gb_q     <= gb_d;
      gneg2_q  <= gneg_q;

      m3_mot_q <= m2_mot_q;
      term_q   <= term_d;
      gterm_q  <= gterm_d;
    end
  end

  // final sums
  always_comb begin
    logic signed [43:0] sx, sy, sz;
    sx = {{12{m3_mot_q.side.ox[31]}}, m3_mot_q.side.ox} + {{2{term_q[0][41]}}, term_q[0]};
    sy = {{12{m3_mot_q.side.oy[31]}}, m3_mot_q.side.oy} + {{2{term_q[1][41]}}, term_q[1]};
    sz = {{12{m3_mot_q.side.oz[31]}}, m3_mot_q.side.oz} + {{2{term_q[2][41]}}, term_q[2]}
         - {{5{gterm_q[38]}}, gterm_q};
    res_o.gtime = m3_mot_q.gtime;
    res_o.reach = m3_mot_q.side.reach;
    res_o.burst = (m3_mot_q.side.func == FUNC_DET) && m3_mot_q.land;
    if (m3_mot_q.side.func == FUNC_TIME) begin
      res_o.px = '0;
      res_o.py = '0;
      res_o.pz = '0;
    end else begin
      res_o.px = sat32(sx);
      res_o.py = sat32(sy);
      res_o.pz = m3_mot_q.land ? m3_mot_q.side.gz : sat32(sz);
    end
  end

  assign valid_o = m3_valid_q;

endmodule

`default_nettype wire

@@ sim/projectile_detonation_point_tb.sv @@
// Testbench for the projectile detonation point pipeline.
`timescale 1ns / 1ps

module projectile_detonation_point_tb;
  import pdp_pkg::*;

  // One throw as the sender sees it
  typedef struct {
    func_e          func;
    logic [31:0]    ox, oy, oz, vx, vy, vz, gz;
    logic [23:0]    tv;
  } throw_t;

  // Predicts each result from the throw and the current gravity, queues it,
  // and compares the block's output transfers against the queue in order.
  class intercept_board;
    res_t        expected_q[$];
    logic [23:0] gravity;
    int          errors;
    int          checked;
    int          landed;
    int          bursts;

    function new();
      gravity = 24'd250880;
      errors  = 0;
      checked = 0;
      landed  = 0;
      bursts  = 0;
    endfunction

    task report(string what, longint got_v, longint exp_v);
      errors++;
      $display("mismatch on result %0d: %s got %0d expected %0d", checked, what, got_v, exp_v);
    endtask

    function longint unsigned root_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // v*t in Q24.8 toward zero, clamped to 2^40
    function longint drift(longint v, longint unsigned t);
      longint unsigned m, hi, lo, p;
      m  = (v < 0) ? longint'(-v) : longint'(v);
      hi = t >> 16;
      lo = t & 64'hFFFF;
      if (hi > 64'h1_0000_0000) hi = 64'h1_0000_0000;
      p = m * hi + ((m * lo) >> 16);
      if (p > 64'h100_0000_0000) p = 64'h100_0000_0000;
      return (v < 0) ? -longint'(p) : longint'(p);
    endfunction

    // g*t*t/2 in Q24.8 toward zero
    function longint fall(longint g, longint unsigned t);
      longint unsigned m, tt, p;
      m  = (g < 0) ? longint'(-g) : longint'(g);
      tt = t * t;
      p  = m * (tt >> 33) + ((m * (tt & 64'h1_FFFF_FFFF)) >> 33);
      return (g < 0) ? -longint'(p) : longint'(p);
    endfunction

    function logic [31:0] clip32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
    endfunction

    function void note_throw(throw_t th);
      longint          ox, oy, oz, vx, vy, vz, gz, tv, g, dz, disc, num;
      longint unsigned tg, t;
      bit              reach, land;
      res_t            r;
      ox = longint'($signed(th.ox)); oy = longint'($signed(th.oy));
      oz = longint'($signed(th.oz)); vx = longint'($signed(th.vx));
      vy = longint'($signed(th.vy)); vz = longint'($signed(th.vz));
      gz = longint'($signed(th.gz)); tv = longint'($signed(th.tv));
      g  = longint'($signed(gravity));
      dz = oz - gz;
      reach = 0;
      land  = 0;
      tg    = 0;
      r     = '0;
      if (g > 0) begin
        disc = vz * vz + 2 * g * dz;
        if (disc >= 0) begin
          num = vz + longint'(root_floor(longint'(disc)));
          if (num >= 0) begin
            reach = 1;
            tg = (longint'(num) << 16) / longint'(g);
          end
        end
      end else if (vz < 0 && dz >= 0) begin
        reach = 1;
        tg = (longint'(dz) << 16) / longint'(-vz);
      end
      if (th.func != FUNC_TIME) begin
        t = (tv > 0) ? longint'(tv) : 0;
        if (th.func == FUNC_LAND) begin
          land = reach;
          if (!reach) t = 0;
        end else if (th.func == FUNC_DET && reach && tg <= t) begin
          land = 1;
          r.burst = 1;
        end
        if (land) begin
          r.px = clip32(ox + drift(vx, tg));
          r.py = clip32(oy + drift(vy, tg));
          r.pz = clip32(gz);
        end else begin
          r.px = clip32(ox + drift(vx, t));
          r.py = clip32(oy + drift(vy, t));
          r.pz = clip32(oz + drift(vz, t) - fall(g, t));
        end
      end
      r.reach = reach;
      r.gtime = !reach ? 23'd0 : (tg > 64'd8388607) ? 23'h7FFFFF : tg[22:0];
      expected_q.push_back(r);
    endfunction

    task check_result(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("output transfer with nothing expected");
        return;
      end
      e = expected_q.pop_front();
      if (got.px !== e.px) report("point_x", $signed(got.px), $signed(e.px));
      if (got.py !== e.py) report("point_y", $signed(got.py), $signed(e.py));
      if (got.pz !== e.pz) report("point_z", $signed(got.pz), $signed(e.pz));
      if (got.gtime !== e.gtime) report("ground_time", got.gtime, e.gtime);
      if (got.reach !== e.reach) report("reaches_ground", got.reach, e.reach);
      if (got.burst !== e.burst) report("burst_on_ground", got.burst, e.burst);
      checked++;
      landed += e.reach;
      bursts += e.burst;
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [23:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [247:0] s_axis_tdata = '0;   // ox, oy, oz, vx, vy, vz, gz, tv
  logic [1:0]   s_axis_tuser = '0;   // func
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;        // px, py, pz, ground_time, pad
  logic [1:0]   m_axis_tuser;        // reaches_ground, burst_on_ground

  intercept_board board = new();

  bit sender_idles;       // per phase: sender draws gaps or streams back to back
  bit hold_request;       // asks the receiver for one long hold-off
  int sent_per_func[4];

  projectile_detonation_point DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  initial begin
    #5ms;
    $display("timeout with %0d results still pending", board.expected_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Input transfers: predict from the throw as it is taken
  always @(posedge clk_i) begin
    throw_t th;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      th.func = func_e'(s_axis_tuser);
      {th.tv, th.gz, th.vz, th.vy, th.vx, th.oz, th.oy, th.ox} = s_axis_tdata;
      board.note_throw(th);
    end
  end

  // Output transfers: compare against the oldest prediction
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.px    = m_axis_tdata[31:0];
      got.py    = m_axis_tdata[63:32];
      got.pz    = m_axis_tdata[95:64];
      got.gtime = m_axis_tdata[118:96];
      got.reach = m_axis_tuser[0];
      got.burst = m_axis_tuser[1];
      board.check_result(got);
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request so the
  // pipeline and its output buffer fill and the input stalls.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_request = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_throw(throw_t th);
    int gap;
    gap = sender_idles ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= th.func;
    s_axis_tdata  <= {th.tv, th.gz, th.vz, th.vy, th.vx, th.oz, th.oy, th.ox};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_per_func[th.func]++;
  endtask

  // Drop valid, drain every expected result, then let the pipe go quiet
  task automatic drain();
    int n;
    s_axis_tvalid <= 1'b0;
    n = 0;
    while (board.expected_q.size() != 0 && n < 20000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_gravity(logic [23:0] g);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= g;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.gravity = g;
  endtask

  function automatic throw_t mk(func_e f, int ox, int oy, int oz, int vx, int vy,
                                int vz, int gz, int tv);
    throw_t th;
    th.func = f;
    th.ox = ox; th.oy = oy; th.oz = oz;
    th.vx = vx; th.vy = vy; th.vz = vz;
    th.gz = gz; th.tv = tv[23:0];
    return th;
  endfunction

  function automatic int span(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // Mostly plausible throws that land within a few seconds, some raw noise,
  // some edge values (zero vertical speed, origin on the plane, odd fuses).
  function automatic throw_t random_throw();
    throw_t th;
    int     kind;
    kind = $urandom_range(0, 99);
    th.func = func_e'($urandom_range(0, 3));
    if (kind < 70) begin
      th.ox = span(1 << 20); th.oy = span(1 << 20);
      th.oz = $urandom_range(0, 1 << 20);
      th.vx = span(1 << 18); th.vy = span(1 << 18);
      th.vz = span(1 << 18);
      th.gz = span(1 << 18);
      th.tv = 24'(span(1 << 18));
    end else if (kind < 85) begin
      th.ox = $urandom; th.oy = $urandom; th.oz = $urandom;
      th.vx = $urandom; th.vy = $urandom; th.vz = $urandom;
      th.gz = $urandom; th.tv = 24'($urandom);
    end else begin
      th.ox = $urandom; th.oy = $urandom;
      th.oz = span(1 << 12);
      th.gz = ($urandom_range(0, 1) != 0) ? th.oz : span(1 << 12);
      th.vx = span(1 << 24); th.vy = span(1 << 24);
      th.vz = ($urandom_range(0, 1) != 0) ? 0 : span(1 << 10);
      case ($urandom_range(0, 3))
        0:       th.tv = 24'h000000;
        1:       th.tv = 24'h800000;
        2:       th.tv = 24'h7FFFFF;
        default: th.tv = 24'($urandom_range(0, 1 << 10));
      endcase
    end
    return th;
  endfunction

  task automatic send_directed_arc();
    int one_s;
    one_s = 1 << 16;
    send_throw(mk(FUNC_POS,  256, -512, 2560, 5120, 2560, 51200, 0, one_s));
    send_throw(mk(FUNC_POS,  256, -512, 2560, 5120, 2560, 51200, 0, 0));
    send_throw(mk(FUNC_POS,  256, -512, 2560, 5120, 2560, 51200, 0, -8388608));
    send_throw(mk(FUNC_TIME, 0, 0, 25600, 2560, 0, 25600, 0, 0));
    // below the plane and heading down: discriminant negative
    send_throw(mk(FUNC_TIME, 0, 0, -25600, 0, 0, -2560, 0, 0));
    // root exists but both crossings lie in the past
    send_throw(mk(FUNC_LAND, 0, 0, -2560, 0, 0, -256000, 0, 0));
    send_throw(mk(FUNC_LAND, 100, 200, 25600, 2560, -2560, 25600, 256, 0));
    send_throw(mk(FUNC_LAND, 100, 200, -25600, 2560, -2560, -25600, 256, one_s));
    // fuse outlasts the flight, fuse shorter than the flight, negative fuse
    send_throw(mk(FUNC_DET, 0, 0, 25600, 2560, 2560, 25600, 0, 20 * one_s));
    send_throw(mk(FUNC_DET, 0, 0, 25600, 2560, 2560, 25600, 0, one_s / 4));
    send_throw(mk(FUNC_DET, 0, 0, 25600, 2560, 2560, 25600, 0, -one_s));
    // already on the plane at rest, zero fuse: lands at time zero
    send_throw(mk(FUNC_DET, 77, 88, 512, 0, 0, 0, 512, 0));
    for (int f = 0; f < 4; f++) begin
      send_throw(mk(func_e'(f), 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                    32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 8388607));
      send_throw(mk(func_e'(f), 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h80000000, 32'h80000000, 32'h7FFFFFFF, -8388608));
    end
  endtask

  task automatic send_directed_line();
    send_throw(mk(FUNC_LAND, 0, 0, 25600, 2560, 2560, -2560, 0, 0));
    send_throw(mk(FUNC_LAND, 0, 0, 25600, 2560, 2560, 0, 0, 0));
    send_throw(mk(FUNC_DET, 0, 0, 25600, 2560, 2560, 2560, 0, 1 << 16));
    send_throw(mk(FUNC_TIME, 0, 0, -25600, 0, 0, -2560, 0, 0));
    send_throw(mk(FUNC_TIME, 0, 0, 32'h7FFFFFFF, 0, 0, 32'h80000000, 32'h80000000, 0));
    send_throw(mk(FUNC_TIME, 0, 0, 32'h7FFFFFFF, 0, 0, -1, 32'h80000000, 0));
  endtask

  initial begin
    logic [23:0] g_plan[9];
    int          per_phase;
    g_plan = '{24'd250880, 24'd0, 24'hFFFB00, 24'h7FFFFF, 24'h800000,
               24'd1, 24'd2560, 24'd0, 24'd250880};
    per_phase = 1950 / 9;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < 9; ph++) begin
      // first phase runs on the reset value; phase 7 draws a random gravity
      if (ph == 7) write_gravity(24'($urandom_range(1, 1 << 20)));
      else if (ph > 0) write_gravity(g_plan[ph]);
      sender_idles = (ph % 2 == 0);
      if (ph == 3) hold_request = 1;
      if (ph == 0) send_directed_arc();
      if (ph == 1) send_directed_line();
      for (int i = 0; i < per_phase; i++) send_throw(random_throw());
      drain();
    end
    $display("sent %0d/%0d/%0d/%0d throws per mode over nine gravity settings",
             sent_per_func[0], sent_per_func[1], sent_per_func[2], sent_per_func[3]);
    $display("%0d results checked, %0d reached the plane, %0d burst on the ground",
             board.checked, board.landed, board.bursts);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
